>>> design/regex_escape_decoder_macros.svh
// ----------------------------------------------------------------------------
// Regex escape decoder assertion macros
// Shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef REGEX_ESCAPE_DECODER_MACROS_SVH
`define REGEX_ESCAPE_DECODER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define RXESC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define RXESC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/rxesc_pkg.sv
// ----------------------------------------------------------------------------
// Regex escape decoder package
// Item types, symbol codes and result helpers shared by the decoder files.
// ----------------------------------------------------------------------------
package rxesc_pkg;

	localparam int SYM_W = 21;
	localparam int ACC_W = 18;
	localparam int CNT_W = 3;

	// Symbols with a meaning after a backslash
	localparam logic [SYM_W-1:0] CH_BSLASH = 21'h00005C;
	localparam logic [SYM_W-1:0] CH_0      = 21'h000030;
	localparam logic [SYM_W-1:0] CH_7      = 21'h000037;
	localparam logic [SYM_W-1:0] CH_8      = 21'h000038;
	localparam logic [SYM_W-1:0] CH_9      = 21'h000039;
	localparam logic [SYM_W-1:0] CH_LC_A   = 21'h000061;
	localparam logic [SYM_W-1:0] CH_LC_E   = 21'h000065;
	localparam logic [SYM_W-1:0] CH_LC_F   = 21'h000066;
	localparam logic [SYM_W-1:0] CH_LC_N   = 21'h00006E;
	localparam logic [SYM_W-1:0] CH_LC_O   = 21'h00006F;
	localparam logic [SYM_W-1:0] CH_LC_R   = 21'h000072;
	localparam logic [SYM_W-1:0] CH_LC_T   = 21'h000074;
	localparam logic [SYM_W-1:0] CH_LC_U   = 21'h000075;
	localparam logic [SYM_W-1:0] CH_LC_X   = 21'h000078;
	localparam logic [SYM_W-1:0] CH_UC_A   = 21'h000041;
	localparam logic [SYM_W-1:0] CH_UC_F   = 21'h000046;

	// Control codes produced by letter escapes
	localparam logic [SYM_W-1:0] CTL_BEL = 21'h000007;
	localparam logic [SYM_W-1:0] CTL_ESC = 21'h00001B;
	localparam logic [SYM_W-1:0] CTL_LF  = 21'h00000A;
	localparam logic [SYM_W-1:0] CTL_CR  = 21'h00000D;
	localparam logic [SYM_W-1:0] CTL_FF  = 21'h00000C;
	localparam logic [SYM_W-1:0] CTL_TAB = 21'h000009;

	// Digit limits of the numeric escapes
	localparam logic [CNT_W-1:0] HEX_U_DIGITS   = 3'd4;
	localparam logic [CNT_W-1:0] HEX_X_DIGITS   = 3'd2;
	localparam logic [CNT_W-1:0] OCT_O_DIGITS   = 3'd6;
	localparam logic [CNT_W-1:0] OCT_REST_DIGITS = 3'd2;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             end_marker;
	} in_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] decoded_symbol;
		logic             from_escape;
		logic             last_of_run;
	} out_item_t;

	// Results of one decoded item, count is 0..2
	typedef struct packed {
		logic [1:0] count;
		out_item_t  first;
		out_item_t  second;
	} dec_res_t;

	function automatic out_item_t mk_result(logic [SYM_W-1:0] value, logic esc);
		out_item_t r;
		r.decoded_symbol = value;
		r.from_escape    = esc;
		r.last_of_run    = 1'b0;
		return r;
	endfunction

endpackage

>>> design/rxesc_if.sv
// ----------------------------------------------------------------------------
// Regex escape decoder channels
// Valid/ready channels for text symbols in and decoded symbols out.
// ----------------------------------------------------------------------------
interface rxesc_in_if;
	logic        valid;
	logic        ready;
	logic [20:0] symbol;
	logic        end_marker;

	modport source (output valid, output symbol, output end_marker, input ready);
	modport sink (input valid, input symbol, input end_marker, output ready);
endinterface

interface rxesc_out_if;
	logic        valid;
	logic        ready;
	logic [20:0] decoded_symbol;
	logic        from_escape;
	logic        last_of_run;

	modport source (output valid, output decoded_symbol, output from_escape,
		output last_of_run, input ready);
	modport sink (input valid, input decoded_symbol, input from_escape,
		input last_of_run, output ready);
endinterface

>>> design/rxesc_in_reg.sv
// ----------------------------------------------------------------------------
// Regex escape decoder input register
// Captures one text item and holds it until the decode stage takes it.
// ----------------------------------------------------------------------------
module rxesc_in_reg import rxesc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	rxesc_in_if.sink      text,
	input  logic          advance,
	output logic          valid_s1,
	output in_item_t      item_s1
);

	// Take a new item when empty or when the held one moves on
	assign text.ready = !valid_s1 || advance;

	// Hold valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	// Load payload on accept
	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			item_s1.symbol     <= text.symbol;
			item_s1.end_marker <= text.end_marker;
		end
	end

endmodule

>>> design/rxesc_core.sv
// ----------------------------------------------------------------------------
// Regex escape decoder core
// Holds the escape state and decodes the registered item into 0..2 results.
// ----------------------------------------------------------------------------
module rxesc_core import rxesc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  item_s1,
	input  logic      advance,
	output dec_res_t  res
);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_ESC,
		MODE_NUM
	} mode_t;

	mode_t             mode_q, mode_d;
	logic [CNT_W-1:0]  left_q, left_d, left_dec;
	logic [ACC_W-1:0]  acc_q, acc_d, acc_shift;
	logic              octal_q, octal_d;
	logic              dig_ok;
	logic [3:0]        dig_val;
	logic [SYM_W-1:0]  sym;

	assign sym      = item_s1.symbol;
	assign left_dec = left_q - 3'd1;

	// Classify the symbol as a digit of the current base
	always_comb begin
		dig_ok  = 1'b0;
		dig_val = 4'd0;
		if (sym >= CH_0 && sym <= CH_7) begin
			dig_ok  = 1'b1;
			dig_val = {1'b0, sym[2:0]};
		end else if (!octal_q && (sym == CH_8 || sym == CH_9)) begin
			dig_ok  = 1'b1;
			dig_val = sym[3:0];
		end else if (!octal_q && ((sym >= CH_LC_A && sym <= CH_LC_F) ||
				(sym >= CH_UC_A && sym <= CH_UC_F))) begin
			dig_ok  = 1'b1;
			dig_val = sym[3:0] + 4'd9;
		end
	end

	// Shift the new digit into the accumulator
	assign acc_shift = octal_q ? {acc_q[ACC_W-4:0], dig_val[2:0]}
	                           : {acc_q[ACC_W-5:0], dig_val};

	// Decode one item against the current state
	always_comb begin
		mode_d       = mode_q;
		left_d       = left_q;
		acc_d        = acc_q;
		octal_d      = octal_q;
		res.count    = 2'd0;
		res.first    = mk_result(sym, 1'b0);
		res.second   = mk_result(sym, 1'b0);

		if (item_s1.end_marker) begin
			// Flush pending escape, return to reset state
			if (mode_q == MODE_ESC) begin
				res.count = 2'd1;
				res.first = mk_result(CH_BSLASH, 1'b1);
			end else if (mode_q == MODE_NUM) begin
				res.count = 2'd1;
				res.first = mk_result(SYM_W'(acc_q), 1'b1);
			end
			mode_d  = MODE_IDLE;
			left_d  = '0;
			acc_d   = '0;
			octal_d = 1'b0;
		end else begin
			unique case (mode_q)
				MODE_ESC: begin
					mode_d = MODE_IDLE;
					unique case (sym) inside
						CH_LC_A: begin
							res.count = 2'd1;
							res.first = mk_result(CTL_BEL, 1'b1);
						end
						CH_LC_E: begin
							res.count = 2'd1;
							res.first = mk_result(CTL_ESC, 1'b1);
						end
						CH_LC_N: begin
							res.count = 2'd1;
							res.first = mk_result(CTL_LF, 1'b1);
						end
						CH_LC_R: begin
							res.count = 2'd1;
							res.first = mk_result(CTL_CR, 1'b1);
						end
						CH_LC_F: begin
							res.count = 2'd1;
							res.first = mk_result(CTL_FF, 1'b1);
						end
						CH_LC_T: begin
							res.count = 2'd1;
							res.first = mk_result(CTL_TAB, 1'b1);
						end
						CH_LC_U: begin
							mode_d  = MODE_NUM;
							octal_d = 1'b0;
							left_d  = HEX_U_DIGITS;
							acc_d   = '0;
						end
						CH_LC_X: begin
							mode_d  = MODE_NUM;
							octal_d = 1'b0;
							left_d  = HEX_X_DIGITS;
							acc_d   = '0;
						end
						CH_LC_O: begin
							mode_d  = MODE_NUM;
							octal_d = 1'b1;
							left_d  = OCT_O_DIGITS;
							acc_d   = '0;
						end
						CH_8, CH_9: begin
							// Zero value, then the digit as a plain symbol
							res.count  = 2'd2;
							res.first  = mk_result('0, 1'b1);
							res.second = mk_result(sym, 1'b0);
						end
						[CH_0:CH_7]: begin
							mode_d  = MODE_NUM;
							octal_d = 1'b1;
							left_d  = OCT_REST_DIGITS;
							acc_d   = ACC_W'(sym[2:0]);
						end
						default: begin
							res.count = 2'd1;
							res.first = mk_result(sym, 1'b1);
						end
					endcase
				end
				MODE_NUM: begin
					if (dig_ok && left_q != '0) begin
						acc_d  = acc_shift;
						left_d = left_dec;
						if (left_dec == '0) begin
							mode_d    = MODE_IDLE;
							res.count = 2'd1;
							res.first = mk_result(SYM_W'(acc_shift), 1'b1);
						end
					end else begin
						// End the number, then decode this symbol as plain text
						res.first = mk_result(SYM_W'(acc_q), 1'b1);
						if (sym == CH_BSLASH) begin
							mode_d    = MODE_ESC;
							res.count = 2'd1;
						end else begin
							mode_d     = MODE_IDLE;
							res.count  = 2'd2;
							res.second = mk_result(sym, 1'b0);
						end
					end
				end
				default: begin
					if (sym == CH_BSLASH) begin
						mode_d = MODE_ESC;
					end else begin
						mode_d    = MODE_IDLE;
						res.count = 2'd1;
						res.first = mk_result(sym, 1'b0);
					end
				end
			endcase
		end

		// Flag the final result of this item
		res.first.last_of_run  = (res.count == 2'd1);
		res.second.last_of_run = 1'b1;
	end

	// Hold state; advance when the item moves to the result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			left_q  <= '0;
			acc_q   <= '0;
			octal_q <= 1'b0;
		end else if (advance) begin
			mode_q  <= mode_d;
			left_q  <= left_d;
			acc_q   <= acc_d;
			octal_q <= octal_d;
		end
	end

endmodule

>>> design/rxesc_out_buf.sv
// ----------------------------------------------------------------------------
// Regex escape decoder result buffer
// Two-entry result register that presents the results of one item in order.
// ----------------------------------------------------------------------------
module rxesc_out_buf import rxesc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s1,
	input  dec_res_t    res,
	output logic        advance,
	rxesc_out_if.source decoded
);

	logic [1:0] cnt_q;
	out_item_t  slot0_q, slot1_q;
	logic       pop;
	logic       room;

	assign pop  = decoded.valid && decoded.ready;
	// Load when empty or when the last held result leaves this cycle
	assign room    = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
	assign advance = valid_s1 && room;

	assign decoded.valid          = (cnt_q != 2'd0);
	assign decoded.decoded_symbol = slot0_q.decoded_symbol;
	assign decoded.from_escape    = slot0_q.from_escape;
	assign decoded.last_of_run    = slot0_q.last_of_run;

	// Track number of held results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (advance) begin
			cnt_q <= res.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Load new results or shift the second forward
	always_ff @(posedge clk) begin
		if (advance) begin
			slot0_q <= res.first;
			slot1_q <= res.second;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

>>> design/regex_escape_decoder.sv
// An accepted item is held in the input register, then its results in the result buffer.
// Throughput: one item per cycle while the output takes each result; an item with
//   two results (a numeric escape ended by a plain symbol, or an escaped 8 or 9)
//   holds the two-entry result buffer, so the next item waits until the second leaves.
// Reset: arst_n clears the escape state, the input valid flag and the result count at once.
// ----------------------------------------------------------------------------
// Regex escape decoder
// Decodes regex text symbols, resolving backslash escapes, one item a cycle when the output keeps up.
// ----------------------------------------------------------------------------
module regex_escape_decoder import rxesc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	rxesc_in_if.sink    text,
	rxesc_out_if.source decoded
);

	logic     valid_s1;
	in_item_t item_s1;
	logic     advance;
	dec_res_t res;

	rxesc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rxesc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.advance (advance),
		.res     (res)
	);

	rxesc_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.res      (res),
		.advance  (advance),
		.decoded  (decoded)
	);

endmodule

>>> design/rxesc_checker.sv
// ----------------------------------------------------------------------------
// Regex escape decoder checker
// Port-level checks on the decoded result stream.
// ----------------------------------------------------------------------------
`include "regex_escape_decoder_macros.svh"

module rxesc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [20:0] out_symbol,
	input logic        out_escape,
	input logic        out_last
);

	// A stalled result stays offered
	`RXESC_ASSERT_NEXT(a_valid_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// A stalled result keeps its value
	`RXESC_ASSERT_NEXT(a_data_hold, clk, arst_n, out_valid && !out_ready, $stable(out_symbol) && $stable(out_escape) && $stable(out_last), "result changed while stalled")

	// A plain symbol is always the final result of its item
	`RXESC_ASSERT_SAME(a_plain_last, clk, arst_n, out_valid && !out_escape, out_last, "plain symbol not last of its item")

	// The second result of an item follows right after the first
	`RXESC_ASSERT_NEXT(a_pair_follows, clk, arst_n, out_valid && out_ready && !out_last, out_valid, "second result of an item missing")

endmodule

bind regex_escape_decoder rxesc_checker u_rxesc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (decoded.valid),
	.out_ready  (decoded.ready),
	.out_symbol (decoded.decoded_symbol),
	.out_escape (decoded.from_escape),
	.out_last   (decoded.last_of_run)
);

>>> tb/regex_escape_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Regex escape decoder testbench
// Drives text symbols, mostly escape sequences with random content, through
// the decoder with random gaps and output stalls. A built-in decoder model
// predicts each decoded symbol, and every output item is compared with it.
// ----------------------------------------------------------------------------
module regex_escape_decoder_test;
	import rxesc_pkg::*;

	localparam int ITEM_TARGET = 650;
	localparam int CYCLE_LIMIT = 100000;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [SYM_W-1:0] SYM_MAX = 21'h1FFFFF;
	localparam logic [SYM_W-1:0] CH_UC_Z = 21'h00005A;
	localparam logic [SYM_W-1:0] ESC_LETTERS [8] = '{CH_LC_A, CH_LC_E, CH_LC_N,
		CH_LC_R, CH_LC_F, CH_LC_T, CH_8, CH_9};

	typedef enum logic [1:0] {
		DEC_IDLE = 2'd0,
		DEC_ESC  = 2'd1,
		DEC_NUM  = 2'd2
	} dec_mode_e;

	logic clk = 1'b0;
	logic arst_n;

	rxesc_in_if  text_ch ();
	rxesc_out_if dec_ch ();

	regex_escape_decoder u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text_ch),
		.decoded (dec_ch)
	);

	// Decoder model state
	dec_mode_e        mode_q;
	logic [CNT_W-1:0] digits_q;
	logic [ACC_W-1:0] acc_q;
	logic             octal_q;

	in_item_t  text_items_q [$];
	out_item_t decoded_exp_q [$];
	out_item_t exp_item;
	logic      text_took;
	int        sent_cnt;
	int        mismatch_cnt;
	int        cycle_cnt;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Decoder model
	// ------------------------------------------------------------------------
	task automatic emit_symbol(logic [SYM_W-1:0] value, logic esc);
		out_item_t r;
		r.decoded_symbol = value;
		r.from_escape    = esc;
		r.last_of_run    = 1'b0;
		decoded_exp_q.push_back(r);
	endtask

	task automatic begin_number(logic octal, logic [CNT_W-1:0] count,
		logic [ACC_W-1:0] init);
		mode_q   = DEC_NUM;
		octal_q  = octal;
		digits_q = count;
		acc_q    = init;
	endtask

	function automatic int digit_weight(logic [SYM_W-1:0] s, logic octal);
		if (s >= CH_0 && s <= CH_7) return int'(s - CH_0);
		if (octal) return -1;
		if (s == CH_8 || s == CH_9) return int'(s - CH_0);
		if (s >= CH_LC_A && s <= CH_LC_F) return int'(s - CH_LC_A) + 10;
		if (s >= CH_UC_A && s <= CH_UC_F) return int'(s - CH_UC_A) + 10;
		return -1;
	endfunction

	task automatic take_plain(logic [SYM_W-1:0] s);
		if (s == CH_BSLASH) begin
			mode_q = DEC_ESC;
		end else begin
			mode_q = DEC_IDLE;
			emit_symbol(s, 1'b0);
		end
	endtask

	task automatic take_escaped(logic [SYM_W-1:0] s);
		mode_q = DEC_IDLE;
		case (s)
			CH_LC_A: emit_symbol(CTL_BEL, 1'b1);
			CH_LC_E: emit_symbol(CTL_ESC, 1'b1);
			CH_LC_N: emit_symbol(CTL_LF, 1'b1);
			CH_LC_R: emit_symbol(CTL_CR, 1'b1);
			CH_LC_F: emit_symbol(CTL_FF, 1'b1);
			CH_LC_T: emit_symbol(CTL_TAB, 1'b1);
			CH_LC_U: begin_number(1'b0, HEX_U_DIGITS, '0);
			CH_LC_X: begin_number(1'b0, HEX_X_DIGITS, '0);
			CH_LC_O: begin_number(1'b1, OCT_O_DIGITS, '0);
			CH_8, CH_9: begin
				emit_symbol('0, 1'b1);
				emit_symbol(s, 1'b0);
			end
			default: begin
				if (s >= CH_0 && s <= CH_7)
					begin_number(1'b1, OCT_REST_DIGITS, ACC_W'(s - CH_0));
				else
					emit_symbol(s, 1'b1);
			end
		endcase
	endtask

	task automatic take_number_symbol(logic [SYM_W-1:0] s);
		int w;
		w = digit_weight(s, octal_q);
		if (w >= 0 && digits_q != 0) begin
			// shift the digit in at the current base
			if (octal_q)
				acc_q = {acc_q[ACC_W-4:0], 3'(w)};
			else
				acc_q = {acc_q[ACC_W-5:0], 4'(w)};
			digits_q = digits_q - 1'b1;
			if (digits_q == 0) begin
				mode_q = DEC_IDLE;
				emit_symbol(SYM_W'(acc_q), 1'b1);
			end
		end else begin
			// close the number, then decode this symbol afresh
			emit_symbol(SYM_W'(acc_q), 1'b1);
			take_plain(s);
		end
	endtask

	task automatic predict_decode(in_item_t it);
		int base;
		base = decoded_exp_q.size();
		if (it.end_marker) begin
			if (mode_q == DEC_ESC)
				emit_symbol(CH_BSLASH, 1'b1);
			else if (mode_q == DEC_NUM)
				emit_symbol(SYM_W'(acc_q), 1'b1);
			mode_q   = DEC_IDLE;
			digits_q = '0;
			acc_q    = '0;
			octal_q  = 1'b0;
		end else begin
			case (mode_q)
				DEC_ESC: take_escaped(it.symbol);
				DEC_NUM: take_number_symbol(it.symbol);
				default: take_plain(it.symbol);
			endcase
		end
		if (decoded_exp_q.size() > base)
			decoded_exp_q[decoded_exp_q.size()-1].last_of_run = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic queue_symbol(logic [SYM_W-1:0] s);
		in_item_t it;
		it.symbol     = s;
		it.end_marker = 1'b0;
		text_items_q.push_back(it);
	endtask

	task automatic queue_end(logic [SYM_W-1:0] s);
		in_item_t it;
		it.symbol     = s;
		it.end_marker = 1'b1;
		text_items_q.push_back(it);
	endtask

	function automatic logic [SYM_W-1:0] rand_hex_digit();
		string hex_chars;
		hex_chars = "0123456789abcdefABCDEF";
		return SYM_W'(hex_chars[$urandom_range(0, 21)]);
	endfunction

	function automatic logic [SYM_W-1:0] rand_printable();
		return SYM_W'($urandom_range(32, 126));
	endfunction

	function automatic logic [SYM_W-1:0] rand_octal_digit();
		return SYM_W'(CH_0 + $urandom_range(0, 7));
	endfunction

	// Queue one numeric escape with a random number of digits
	task automatic queue_number();
		int kind;
		int ndig;
		kind = $urandom_range(0, 3);
		queue_symbol(CH_BSLASH);
		case (kind)
			0: begin
				queue_symbol(CH_LC_U);
				ndig = $urandom_range(0, HEX_U_DIGITS);
				repeat (ndig) queue_symbol(rand_hex_digit());
			end
			1: begin
				queue_symbol(CH_LC_X);
				ndig = $urandom_range(0, HEX_X_DIGITS);
				repeat (ndig) queue_symbol(rand_hex_digit());
			end
			2: begin
				queue_symbol(CH_LC_O);
				ndig = $urandom_range(0, OCT_O_DIGITS);
				repeat (ndig) queue_symbol(rand_octal_digit());
			end
			default: begin
				queue_symbol(rand_octal_digit());
				ndig = $urandom_range(0, OCT_REST_DIGITS);
				repeat (ndig) queue_symbol(rand_octal_digit());
			end
		endcase
		// sometimes close with an end marker, an 8 or 9, or a printable symbol
		case ($urandom_range(0, 5))
			0: queue_end(SYM_W'($urandom));
			1: queue_symbol(($urandom_range(0, 1) != 0) ? CH_8 : CH_9);
			2: queue_symbol(rand_printable());
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Input driver: new item at the falling edge
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			text_ch.valid <= 1'b0;
			dec_ch.ready  <= 1'b0;
		end else begin
			if (!text_ch.valid || text_took) begin
				if (text_items_q.size() != 0 &&
				    ((sent_cnt >= 250 && sent_cnt < 400) || $urandom_range(99) >= 25)) begin
					text_ch.valid      <= 1'b1;
					text_ch.symbol     <= text_items_q[0].symbol;
					text_ch.end_marker <= text_items_q[0].end_marker;
					void'(text_items_q.pop_front());
					sent_cnt++;
				end else begin
					text_ch.valid <= 1'b0;
				end
			end
			dec_ch.ready <= (sent_cnt >= 250 && sent_cnt < 400) || ($urandom_range(99) >= 25);
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check results, then predict from the accepted item
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			text_took <= 1'b0;
		end else begin
			if (dec_ch.valid && dec_ch.ready) begin
				if (decoded_exp_q.size() == 0) begin
					$error("unexpected item: decoded_symbol %h", dec_ch.decoded_symbol);
					mismatch_cnt++;
				end else begin
					exp_item = decoded_exp_q.pop_front();
					if (dec_ch.decoded_symbol !== exp_item.decoded_symbol) begin
						$error("decoded_symbol: expected %h, actual %h",
							exp_item.decoded_symbol, dec_ch.decoded_symbol);
						mismatch_cnt++;
					end
					if (dec_ch.from_escape !== exp_item.from_escape) begin
						$error("from_escape: expected %b, actual %b",
							exp_item.from_escape, dec_ch.from_escape);
						mismatch_cnt++;
					end
					if (dec_ch.last_of_run !== exp_item.last_of_run) begin
						$error("last_of_run: expected %b, actual %b",
							exp_item.last_of_run, dec_ch.last_of_run);
						mismatch_cnt++;
					end
				end
			end
			text_took <= text_ch.valid && text_ch.ready;
			if (text_ch.valid && text_ch.ready)
				predict_decode('{symbol: text_ch.symbol, end_marker: text_ch.end_marker});
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		int pick;
		arst_n             = 1'b0;
		text_ch.valid      = 1'b0;
		text_ch.symbol     = '0;
		text_ch.end_marker = 1'b0;
		dec_ch.ready       = 1'b0;
		text_took          = 1'b0;
		sent_cnt           = 0;
		mismatch_cnt       = 0;
		cycle_cnt          = 0;
		mode_q             = DEC_IDLE;
		digits_q           = '0;
		acc_q              = '0;
		octal_q            = 1'b0;

		// plain symbols at both extremes
		queue_symbol('0);
		queue_symbol(SYM_MAX);
		// every control-code letter escape
		for (int i = 0; i < 6; i++) begin
			queue_symbol(CH_BSLASH);
			queue_symbol(ESC_LETTERS[i]);
		end
		// escaped 9: zero, then the digit itself
		queue_symbol(CH_BSLASH);
		queue_symbol(CH_9);
		// empty hex number closed by a backslash, then end after a lone backslash
		queue_symbol(CH_BSLASH);
		queue_symbol(CH_LC_X);
		queue_symbol(CH_BSLASH);
		queue_end(SYM_MAX);
		// end marker while idle
		queue_end('0);
		// full octal number fills the accumulator
		queue_symbol(CH_BSLASH);
		queue_symbol(CH_LC_O);
		repeat (6) queue_symbol(CH_7);
		// end marker inside a number; escaped uppercase F passes through
		queue_symbol(CH_BSLASH);
		queue_symbol(CH_UC_F);
		queue_symbol(CH_BSLASH);
		queue_symbol(CH_LC_U);
		queue_symbol(CH_UC_F);
		queue_end('0);

		// random part: mostly escape sequences, some noise
		while (text_items_q.size() < ITEM_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				queue_symbol(rand_printable());
			end else if (pick < 30) begin
				queue_symbol(SYM_W'($urandom));
			end else if (pick < 48) begin
				queue_symbol(CH_BSLASH);
				if ($urandom_range(0, 3) == 0)
					queue_symbol(($urandom_range(0, 1) != 0) ? rand_printable() : CH_UC_Z);
				else
					queue_symbol(ESC_LETTERS[$urandom_range(0, 7)]);
			end else if (pick < 85) begin
				queue_number();
			end else if (pick < 93) begin
				queue_end(SYM_W'($urandom));
			end else begin
				// broken sequences
				queue_symbol(CH_BSLASH);
				if ($urandom_range(0, 1) != 0)
					queue_end(SYM_W'($urandom));
				else
					queue_symbol(CH_BSLASH);
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for all items to go in and all results to come out
		while (text_items_q.size() != 0 || text_ch.valid || decoded_exp_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_cnt == 0 && decoded_exp_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
